// ----- design/lkv_pkg.sv -----
// Shared constants, types and control structures of the LRU key/value cache.
package lkv_pkg;

    localparam int LKV_MAX_ENTRIES = 16;
    localparam int LKV_DATA_WIDTH  = 32;
    localparam int LKV_FIELD_W     = 32;
    localparam int LKV_CAP_W       = 5;
    localparam int LKV_APB_AW      = 3;
    localparam int LKV_APB_DW      = 32;

    localparam logic [LKV_CAP_W-1:0] LKV_CAP_RESET = 5'd16;

    // Register index, taken from paddr above the byte offset.
    localparam logic [LKV_APB_AW-3:0] REG_CACHE_CAPACITY = 1'b0;

    localparam logic MODE_GET = 1'b0;
    localparam logic MODE_PUT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_SEL,
        ST_UPD
    } t_state;

    // Phase strobes and item attributes broadcast to every cell.
    typedef struct packed {
        logic cmp;
        logic sel;
        logic upd;
        logic put;
        logic hit;
        logic evict;
    } t_cell_ctl;

    // Priority tokens handed from one cell to the next.
    typedef struct packed {
        logic match_seen;
        logic free_seen;
    } t_chain;

endpackage

// ----- design/lkv_req_if.sv -----
// Request channel: one access item per handshake.
interface lkv_req_if;
    logic               valid;
    logic               ready;
    logic               mode;
    logic signed [31:0] lookup_key;
    logic signed [31:0] write_value;

    modport source(output valid, output mode, output lookup_key, output write_value,
                   input ready);
    modport sink(input valid, input mode, input lookup_key, input write_value,
                 output ready);
endinterface

// ----- design/lkv_rsp_if.sv -----
// Response channel: one result item per access.
interface lkv_rsp_if;
    logic               valid;
    logic               ready;
    logic               hit;
    logic signed [31:0] read_value;

    modport source(output valid, output hit, output read_value, input ready);
    modport sink(input valid, input hit, input read_value, output ready);
endinterface

// ----- design/lkv_apb_regs.sv -----
// APB configuration register holding the cache capacity.
module lkv_apb_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lkv_pkg::LKV_APB_AW-1:0]      paddr,
    input  logic [lkv_pkg::LKV_APB_DW-1:0]      pwdata,
    output logic [lkv_pkg::LKV_APB_DW-1:0]      prdata,
    output logic                                pready,
    output logic [lkv_pkg::LKV_CAP_W-1:0]       o_capacity
);
    import lkv_pkg::*;

    logic [LKV_CAP_W-1:0]  r_cap;
    logic [LKV_APB_AW-3:0] w_idx;
    logic                  w_wr;

    assign w_idx  = paddr[LKV_APB_AW-1:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= LKV_CAP_RESET;
        end else if (w_wr && w_idx == REG_CACHE_CAPACITY) begin
            r_cap <= pwdata[LKV_CAP_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (w_idx == REG_CACHE_CAPACITY) begin
            prdata = LKV_APB_DW'(r_cap);
        end
    end

    assign o_capacity = r_cap;
endmodule

// ----- design/lkv_cell.sv -----
// One cache entry: key, value, valid and recency rank, with its link in the priority chain.
module lkv_cell #(
    parameter int DATA_WIDTH = lkv_pkg::LKV_DATA_WIDTH,
    parameter int RANK_W     = 4
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  lkv_pkg::t_cell_ctl      i_ctl,
    input  logic [DATA_WIDTH-1:0]   i_key,
    input  logic [DATA_WIDTH-1:0]   i_value,
    input  logic [RANK_W-1:0]       i_last_rank,
    input  logic [RANK_W-1:0]       i_old_rank,
    input  lkv_pkg::t_chain         i_chain,
    output lkv_pkg::t_chain         o_chain,
    input  logic [DATA_WIDTH-1:0]   i_hit_value,
    output logic [DATA_WIDTH-1:0]   o_hit_value,
    input  logic [RANK_W-1:0]       i_hit_rank,
    output logic [RANK_W-1:0]       o_hit_rank
);
    import lkv_pkg::*;

    logic [DATA_WIDTH-1:0] r_key;
    logic [DATA_WIDTH-1:0] r_value;
    logic                  r_valid;
    logic [RANK_W-1:0]     r_rank;
    logic                  r_match;
    logic                  r_first_match;
    logic                  r_first_free;
    logic                  r_victim;

    logic w_first_match;
    logic w_first_free;
    logic w_target;
    logic w_fresh;
    logic w_age;

    // Only the lowest matching and the lowest free cell claim their token.
    assign w_first_match = r_match && !i_chain.match_seen;
    assign w_first_free  = !r_valid && !i_chain.free_seen;

    assign o_chain.match_seen = i_chain.match_seen || r_match;
    assign o_chain.free_seen  = i_chain.free_seen || !r_valid;
    assign o_hit_value = i_hit_value | (w_first_match ? r_value : '0);
    assign o_hit_rank  = i_hit_rank | (w_first_match ? r_rank : '0);

    assign w_fresh = i_ctl.put && !i_ctl.hit && !i_ctl.evict;

    always_comb begin
        w_target = 1'b0;
        if (i_ctl.hit) begin
            w_target = r_first_match;
        end else if (i_ctl.put) begin
            w_target = i_ctl.evict ? r_victim : r_first_free;
        end
    end

    assign w_age = (i_ctl.hit || i_ctl.put) && r_valid && (w_fresh || r_rank < i_old_rank);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_rank  <= '0;
        end else if (i_ctl.upd) begin
            if (w_target) begin
                r_valid <= 1'b1;
                r_rank  <= '0;
            end else if (w_age) begin
                r_rank <= r_rank + RANK_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp) begin
            r_match <= r_valid && (r_key == i_key);
        end
        if (i_ctl.sel) begin
            r_first_match <= w_first_match;
            r_first_free  <= w_first_free;
            r_victim      <= r_valid && (r_rank == i_last_rank);
        end
        if (i_ctl.upd && w_target && i_ctl.put) begin
            r_key   <= i_key;
            r_value <= i_value;
        end
    end
endmodule

// ----- design/lru_key_value_cache.sv -----
// Top level of the fully associative LRU key/value cache.
// Each access item (get or put) runs in steps: the item is captured, every cell
// compares its key in parallel, the priority chain through the cell row picks the hit,
// free or least recent entry, and the update is broadcast to all cells at once. The update
// waits while the previous response is still stalled. A new item is accepted only once the
// previous one has reached the response register, so items never overlap in the three
// passes through the cell row. Capacity is read from the APB register at byte address 0;
// a value of 0 acts as 1 and values above MAX_ENTRIES act as MAX_ENTRIES.
module lru_key_value_cache #(
    parameter int MAX_ENTRIES = lkv_pkg::LKV_MAX_ENTRIES,
    parameter int DATA_WIDTH  = lkv_pkg::LKV_DATA_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    lkv_req_if.sink                           i_req,
    lkv_rsp_if.source                         o_rsp,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lkv_pkg::LKV_APB_AW-1:0]    paddr,
    input  logic [lkv_pkg::LKV_APB_DW-1:0]    pwdata,
    output logic [lkv_pkg::LKV_APB_DW-1:0]    prdata,
    output logic                              pready
);
    import lkv_pkg::*;

    localparam int UW     = $clog2(MAX_ENTRIES + 1);
    localparam int RANK_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    t_state r_state, n_state;

    logic                  r_mode;
    logic [DATA_WIDTH-1:0] r_key;
    logic [DATA_WIDTH-1:0] r_wval;
    logic                  r_hit;
    logic [DATA_WIDTH-1:0] r_hit_value;
    logic [RANK_W-1:0]     r_hit_rank;
    logic [UW-1:0]         r_used;
    logic                  r_out_valid;
    logic                  r_out_hit;
    logic [LKV_FIELD_W-1:0] r_out_value;

    logic [LKV_CAP_W-1:0]  w_cap;
    logic [UW-1:0]         w_cap_eff;
    logic                  w_evict;
    logic                  w_accept;
    logic                  w_do_upd;
    logic [RANK_W-1:0]     w_last_rank;
    logic [RANK_W-1:0]     w_old_rank;
    t_cell_ctl             w_ctl;

    t_chain                w_chain [MAX_ENTRIES+1];
    logic [DATA_WIDTH-1:0] w_hval  [MAX_ENTRIES+1];
    logic [RANK_W-1:0]     w_hrank [MAX_ENTRIES+1];

    lkv_apb_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_capacity (w_cap)
    );

    always_comb begin
        priority if (w_cap == '0) begin
            w_cap_eff = UW'(1);
        end else if (32'(w_cap) > 32'(MAX_ENTRIES)) begin
            w_cap_eff = UW'(MAX_ENTRIES);
        end else begin
            w_cap_eff = UW'(w_cap);
        end
    end

    assign w_evict     = r_used >= w_cap_eff;
    assign w_last_rank = RANK_W'(r_used - UW'(1));
    // On a hit the entry's own rank bounds the aging; on an eviction it is the oldest.
    assign w_old_rank  = r_hit ? r_hit_rank : w_last_rank;

    assign w_accept    = i_req.valid && i_req.ready;
    assign w_do_upd    = (r_state == ST_UPD) && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        w_ctl     = '0;
        w_ctl.put = (r_mode == MODE_PUT);
        w_ctl.hit = r_hit;
        w_ctl.evict = w_evict;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_CMP;
                end
            end
            ST_CMP: begin
                w_ctl.cmp = 1'b1;
                n_state   = ST_SEL;
            end
            ST_SEL: begin
                w_ctl.sel = 1'b1;
                n_state   = ST_UPD;
            end
            ST_UPD: begin
                if (w_do_upd) begin
                    w_ctl.upd = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign w_chain[0] = '0;
    assign w_hval[0]  = '0;
    assign w_hrank[0] = '0;

    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        lkv_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .RANK_W     (RANK_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_key       (r_key),
            .i_value     (r_wval),
            .i_last_rank (w_last_rank),
            .i_old_rank  (w_old_rank),
            .i_chain     (w_chain[g]),
            .o_chain     (w_chain[g+1]),
            .i_hit_value (w_hval[g]),
            .o_hit_value (w_hval[g+1]),
            .i_hit_rank  (w_hrank[g]),
            .o_hit_rank  (w_hrank[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode <= i_req.mode;
            r_key  <= DATA_WIDTH'($unsigned(i_req.lookup_key));
            r_wval <= DATA_WIDTH'($unsigned(i_req.write_value));
        end
        if (r_state == ST_SEL) begin
            r_hit       <= w_chain[MAX_ENTRIES].match_seen;
            r_hit_value <= w_hval[MAX_ENTRIES];
            r_hit_rank  <= w_hrank[MAX_ENTRIES];
        end
        if (w_do_upd) begin
            r_out_hit <= r_hit;
            priority if (r_mode == MODE_PUT) begin
                r_out_value <= '0;
            end else if (r_hit) begin
                r_out_value <= LKV_FIELD_W'(r_hit_value);
            end else begin
                r_out_value <= '1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_do_upd && r_mode == MODE_PUT && !r_hit && !w_evict) begin
                r_used <= r_used + UW'(1);
            end
            if (w_do_upd) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.hit        = r_out_hit;
    assign o_rsp.read_value = r_out_value;

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_used) <= 32'(MAX_ENTRIES))
        else $error("entry count exceeds the number of cells");

    a_rsp_from_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == ST_UPD)
        else $error("response raised outside the update phase");

    a_miss_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_do_upd && r_mode == MODE_GET && !r_hit |=> o_rsp.valid && !o_rsp.hit
            && o_rsp.read_value == '1)
        else $error("get miss did not return all ones");

    a_fill_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_do_upd && r_mode == MODE_PUT && !r_hit && !w_evict |=> r_used == $past(r_used) + UW'(1))
        else $error("fill of a free entry did not advance the entry count");
endmodule
